### hdl/cpim_pkg.sv
// ----------------------------------------------------------------------------
// cpim_pkg: shared types and constants of the cell pair index merge
// Request and response payload structs, field widths, the reciprocal
// format used by the digit lanes and the register map of the CSR port.
// ----------------------------------------------------------------------------
package cpim_pkg;

   localparam int CELL_W   = 16;
   localparam int SPLIT_W  = 8;
   localparam int MERGED_W = 32;
   localparam int EXT_W    = 40;
   localparam int COORDS_W = 16;

   // Reciprocal of the radix as floor(2^RECIP_SHIFT / radix).
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 20;

   localparam int RES_REG_W  = 5;
   localparam int RANK_REG_W = 3;
   localparam int SRV_W      = 9;
   localparam int SRV_MAX    = 256;

   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_RESOLUTION = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_RANK       = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_SERVERS    = 2'd2;

   localparam logic [RES_REG_W-1:0]  RES_RESET  = 5'd16;
   localparam logic [RANK_REG_W-1:0] RANK_RESET = 3'd2;
   localparam logic [SRV_W-1:0]      SRV_RESET  = 9'd1;

   typedef struct packed {
      logic [CELL_W-1:0]  outer_cell;
      logic [CELL_W-1:0]  inner_cell;
      logic [SPLIT_W-1:0] split_index;
   } req_type;

   typedef struct packed {
      logic                pair_valid;
      logic                range_error;
      logic [MERGED_W-1:0] merged_index;
      logic [EXT_W-1:0]    extended_index;
      logic [COORDS_W-1:0] outer_coords;
      logic [COORDS_W-1:0] inner_coords;
   } rsp_type;

endpackage

### hdl/cpim_lane.sv
// ----------------------------------------------------------------------------
// cpim_lane: radix digit decoder for one cell index
// Takes a cell index apart into one coordinate per dimension, lowest
// dimension first, with two pipeline stages per digit, and flags a cell
// that does not fit in the configured number of dimensions.
// ----------------------------------------------------------------------------
module cpim_lane #(
   parameter int MAX_RANK   = 4,
   parameter int COORD_BITS = 4
) (
   input  logic                                 clock,
   input  logic [2*MAX_RANK-1:0]                en,
   input  logic [cpim_pkg::CELL_W-1:0]          cell_idx,
   input  logic [COORD_BITS:0]                  eff_res,
   input  logic [cpim_pkg::RECIP_W-1:0]         recip,
   input  logic [$clog2(MAX_RANK+1)-1:0]        eff_rank,
   output logic [MAX_RANK*COORD_BITS-1:0]       coords,
   output logic                                 overflow
);

   localparam int CELL_W      = cpim_pkg::CELL_W;
   localparam int RECIP_W     = cpim_pkg::RECIP_W;
   localparam int RECIP_SHIFT = cpim_pkg::RECIP_SHIFT;
   localparam int RES_W       = COORD_BITS + 1;
   localparam int RANK_W      = $clog2(MAX_RANK + 1);
   localparam int PACK_W      = MAX_RANK * COORD_BITS;
   localparam int PROD_W      = CELL_W + RECIP_W;
   localparam int REM_W       = CELL_W + RES_W;

   // First stage of a digit: estimated quotient, at most one too small.
   logic [CELL_W-1:0] xa_ff   [MAX_RANK];
   logic [CELL_W-1:0] qe_ff   [MAX_RANK];
   logic [PACK_W-1:0] packa_ff[MAX_RANK];
   logic              ovfa_ff [MAX_RANK];
   logic [CELL_W-1:0] xa_in   [MAX_RANK];
   logic [CELL_W-1:0] qe_in   [MAX_RANK];
   logic [PACK_W-1:0] packa_in[MAX_RANK];
   logic              ovfa_in [MAX_RANK];

   // Second stage: corrected quotient and the digit.
   logic [CELL_W-1:0] xq_ff   [MAX_RANK];
   logic [PACK_W-1:0] packb_ff[MAX_RANK];
   logic              ovfb_ff [MAX_RANK];
   logic [CELL_W-1:0] xq_in   [MAX_RANK];
   logic [PACK_W-1:0] packb_in[MAX_RANK];
   logic              ovfb_in [MAX_RANK];

   logic [PROD_W-1:0]     prod  [MAX_RANK];
   logic [REM_W-1:0]      back  [MAX_RANK];
   logic [REM_W-1:0]      diff  [MAX_RANK];
   logic [RES_W-1:0]      rem   [MAX_RANK];
   logic [COORD_BITS-1:0] digit [MAX_RANK];

   always_comb begin
      for (int d = 0; d < MAX_RANK; d++) begin
         if (d == 0) begin
            xa_in[d]    = cell_idx;
            packa_in[d] = '0;
            ovfa_in[d]  = 1'b0;
         end else begin
            xa_in[d]    = xq_ff[d-1];
            packa_in[d] = packb_ff[d-1];
            ovfa_in[d]  = ovfb_ff[d-1];
         end
         prod[d]  = PROD_W'(xa_in[d]) * PROD_W'(recip);
         qe_in[d] = prod[d][RECIP_SHIFT +: CELL_W];
      end
   end

   always_comb begin
      for (int d = 0; d < MAX_RANK; d++) begin
         back[d] = REM_W'(qe_ff[d]) * REM_W'(eff_res);
         diff[d] = REM_W'(xa_ff[d]) - back[d];
         // The estimate leaves a remainder below twice the radix.
         if (diff[d][RES_W-1:0] >= eff_res) begin
            xq_in[d] = qe_ff[d] + CELL_W'(1);
            rem[d]   = diff[d][RES_W-1:0] - eff_res;
         end else begin
            xq_in[d] = qe_ff[d];
            rem[d]   = diff[d][RES_W-1:0];
         end
         if (RANK_W'(d) < eff_rank) begin
            digit[d] = rem[d][COORD_BITS-1:0];
         end else begin
            digit[d] = '0;
         end
         packb_in[d] = packa_ff[d];
         packb_in[d][d*COORD_BITS +: COORD_BITS] = digit[d];
         // Whatever is left above the top dimension means the cell is too large.
         ovfb_in[d] = ovfa_ff[d]
                    | ((RANK_W'(d + 1) == eff_rank) && (xq_in[d] != '0));
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < MAX_RANK; d++) begin
         if (en[2*d]) begin
            xa_ff[d]    <= xa_in[d];
            qe_ff[d]    <= qe_in[d];
            packa_ff[d] <= packa_in[d];
            ovfa_ff[d]  <= ovfa_in[d];
         end
         if (en[2*d+1]) begin
            xq_ff[d]    <= xq_in[d];
            packb_ff[d] <= packb_in[d];
            ovfb_ff[d]  <= ovfb_in[d];
         end
      end
   end

   assign coords   = packb_ff[MAX_RANK-1];
   assign overflow = ovfb_ff[MAX_RANK-1];

endmodule

### hdl/cpim_merge.sv
// ----------------------------------------------------------------------------
// cpim_merge: combines the coordinates of the outer and inner lanes
// Checks the pair dimension by dimension, builds the interleaved index by
// Horner steps, one digit per stage, and forms the extended index and the
// response in its output register.
// ----------------------------------------------------------------------------
module cpim_merge #(
   parameter int MAX_RANK   = 4,
   parameter int COORD_BITS = 4
) (
   input  logic                                clock,
   input  logic [2*MAX_RANK:0]                 en,
   input  logic [MAX_RANK*COORD_BITS-1:0]      outer_pack,
   input  logic [MAX_RANK*COORD_BITS-1:0]      inner_pack,
   input  logic                                outer_ovf,
   input  logic                                inner_ovf,
   input  logic [cpim_pkg::SPLIT_W-1:0]        split,
   input  logic [COORD_BITS:0]                 eff_res,
   input  logic [cpim_pkg::SRV_W-1:0]          eff_srv,
   output cpim_pkg::rsp_type                   rsp
);

   localparam int HSTG     = 2 * MAX_RANK;
   localparam int PACK_W   = MAX_RANK * COORD_BITS;
   localparam int MERGED_W = cpim_pkg::MERGED_W;
   localparam int EXT_W    = cpim_pkg::EXT_W;
   localparam int SPLIT_W  = cpim_pkg::SPLIT_W;
   localparam int COORDS_W = cpim_pkg::COORDS_W;

   logic [MERGED_W-1:0] m_ff   [HSTG];
   logic                ok_ff  [HSTG];
   logic                err_ff [HSTG];
   logic [PACK_W-1:0]   op_ff  [HSTG];
   logic [PACK_W-1:0]   ip_ff  [HSTG];
   logic [SPLIT_W-1:0]  sp_ff  [HSTG];

   logic [MERGED_W-1:0]   m_in  [HSTG];
   logic [COORD_BITS-1:0] dig   [HSTG];
   logic                  ok_in;
   logic [EXT_W-1:0]      ext_prod;
   logic [EXT_W-1:0]      ext_sum;
   logic                  good;
   cpim_pkg::rsp_type     rsp_in;
   cpim_pkg::rsp_type     rsp_ff;

   always_comb begin
      ok_in = 1'b1;
      for (int d = 0; d < MAX_RANK; d++) begin
         if (outer_pack[d*COORD_BITS +: COORD_BITS] > inner_pack[d*COORD_BITS +: COORD_BITS]) begin
            ok_in = 1'b0;
         end
      end
   end

   // Digits enter from the top: inner then outer for each dimension.
   always_comb begin
      dig[0]  = inner_pack[(MAX_RANK-1)*COORD_BITS +: COORD_BITS];
      m_in[0] = MERGED_W'(dig[0]);
      for (int j = 1; j < HSTG; j++) begin
         if (j % 2 == 0) begin
            dig[j] = ip_ff[j-1][(MAX_RANK-1-j/2)*COORD_BITS +: COORD_BITS];
         end else begin
            dig[j] = op_ff[j-1][(MAX_RANK-1-j/2)*COORD_BITS +: COORD_BITS];
         end
         m_in[j] = m_ff[j-1] * MERGED_W'(eff_res) + MERGED_W'(dig[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         m_ff[0]   <= m_in[0];
         ok_ff[0]  <= ok_in;
         err_ff[0] <= outer_ovf | inner_ovf;
         op_ff[0]  <= outer_pack;
         ip_ff[0]  <= inner_pack;
         sp_ff[0]  <= split;
      end
      for (int j = 1; j < HSTG; j++) begin
         if (en[j]) begin
            m_ff[j]   <= m_in[j];
            ok_ff[j]  <= ok_ff[j-1];
            err_ff[j] <= err_ff[j-1];
            op_ff[j]  <= op_ff[j-1];
            ip_ff[j]  <= ip_ff[j-1];
            sp_ff[j]  <= sp_ff[j-1];
         end
      end
   end

   always_comb begin
      ext_prod = EXT_W'(eff_srv) * EXT_W'(m_ff[HSTG-1]);
      ext_sum  = ext_prod + EXT_W'(sp_ff[HSTG-1]);
      good     = ok_ff[HSTG-1] && !err_ff[HSTG-1];
      rsp_in.range_error    = err_ff[HSTG-1];
      rsp_in.pair_valid     = good;
      rsp_in.merged_index   = good ? m_ff[HSTG-1] : '0;
      rsp_in.extended_index = good ? ext_sum : '0;
      if (err_ff[HSTG-1]) begin
         rsp_in.outer_coords = '0;
         rsp_in.inner_coords = '0;
      end else begin
         rsp_in.outer_coords = COORDS_W'(op_ff[HSTG-1]);
         rsp_in.inner_coords = COORDS_W'(ip_ff[HSTG-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[HSTG]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

### hdl/cell_pair_index_merge.sv
// ----------------------------------------------------------------------------
// cell_pair_index_merge: merges an outer and an inner cell index
// A request carries two linear cell indices and a split number. Both cells
// are decoded into per-dimension coordinates, checked pairwise, interleaved
// into a merged index and scaled into an extended index.
//
// Channels: req_valid/req_stall/req_data take requests, rsp_valid/rsp_stall/
// rsp_data deliver exactly one response per request, in order. An APB-style
// port sets resolution (0x0), rank (0x4) and server count (0x8); it is to
// be written only while no request is in flight.
// Throughput is one request per cycle while req_stall is low. A request
// passes through two stages per digit in each of the two decoding lanes,
// which share the reciprocal of the radix for their multiply-based divide,
// then one Horner multiply stage per merged digit and one stage for the
// extended index, which is the output register.
// Every stage has a valid bit. When the receiver stalls, the response is
// held and requests keep flowing into empty stages; req_stall rises only
// once every stage is occupied. Reset empties the pipeline and loads
// resolution 16, rank 2 and server count 1; no clearing pass follows.
// ----------------------------------------------------------------------------
module cell_pair_index_merge #(
   parameter int MAX_RANK   = 4,
   parameter int COORD_BITS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cpim_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cpim_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cpim_pkg::ADDR_W-1:0]   paddr,
   input  logic [cpim_pkg::DATA_W-1:0]   pwdata,
   output logic [cpim_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   localparam int LANE_D      = 2 * MAX_RANK;
   localparam int DEPTH       = 4 * MAX_RANK + 1;
   localparam int RES_W       = COORD_BITS + 1;
   localparam int RANK_W      = $clog2(MAX_RANK + 1);
   localparam int PACK_W      = MAX_RANK * COORD_BITS;
   localparam int RMAX        = 1 << COORD_BITS;
   localparam int RECIP_W     = cpim_pkg::RECIP_W;
   localparam int RECIP_SHIFT = cpim_pkg::RECIP_SHIFT;
   localparam int SRV_W       = cpim_pkg::SRV_W;
   localparam int DATA_W      = cpim_pkg::DATA_W;
   localparam int IDX_W       = cpim_pkg::REG_IDX_W;

   // ---------------- configuration registers ----------------
   logic [cpim_pkg::RES_REG_W-1:0]  res_ff, res_in;
   logic [cpim_pkg::RANK_REG_W-1:0] rank_ff, rank_in;
   logic [SRV_W-1:0]                srv_ff, srv_in;
   logic [RES_W-1:0]                eff_res_ff, eff_res_in;
   logic [RECIP_W-1:0]              recip_ff, recip_in;
   logic [RANK_W-1:0]               eff_rank_ff, eff_rank_in;
   logic [SRV_W-1:0]                eff_srv_ff, eff_srv_in;
   logic                            wr;
   logic [IDX_W-1:0]                idx;
   logic [RECIP_W-1:0]              recip_tab [RMAX+1];

   for (genvar g = 0; g <= RMAX; g++) begin : g_recip
      localparam int DIV = (g < 2) ? 2 : g;
      localparam int RC  = (1 << RECIP_SHIFT) / DIV;
      assign recip_tab[g] = RECIP_W'(RC);
   end

   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[IDX_W+1:2];
   assign pready = 1'b1;

   // The derived values follow the next register contents, so they are
   // right as soon as the registers are, after reset or a write.
   always_comb begin
      res_in  = res_ff;
      rank_in = rank_ff;
      srv_in  = srv_ff;
      if (reset) begin
         res_in  = cpim_pkg::RES_RESET;
         rank_in = cpim_pkg::RANK_RESET;
         srv_in  = cpim_pkg::SRV_RESET;
      end else if (wr) begin
         case (idx)
            cpim_pkg::REG_RESOLUTION: res_in  = pwdata[cpim_pkg::RES_REG_W-1:0];
            cpim_pkg::REG_RANK:       rank_in = pwdata[cpim_pkg::RANK_REG_W-1:0];
            cpim_pkg::REG_SERVERS:    srv_in  = pwdata[SRV_W-1:0];
            default: ;
         endcase
      end

      if (res_in < 2) begin
         eff_res_in = RES_W'(2);
      end else if (32'(res_in) > RMAX) begin
         eff_res_in = RES_W'(RMAX);
      end else begin
         eff_res_in = RES_W'(res_in);
      end
      recip_in = recip_tab[eff_res_in];

      if (rank_in == '0) begin
         eff_rank_in = RANK_W'(1);
      end else if (32'(rank_in) > MAX_RANK) begin
         eff_rank_in = RANK_W'(MAX_RANK);
      end else begin
         eff_rank_in = RANK_W'(rank_in);
      end

      if (srv_in == '0) begin
         eff_srv_in = SRV_W'(1);
      end else if (32'(srv_in) > cpim_pkg::SRV_MAX) begin
         eff_srv_in = SRV_W'(cpim_pkg::SRV_MAX);
      end else begin
         eff_srv_in = srv_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rank_ff     <= rank_in;
      srv_ff      <= srv_in;
      eff_res_ff  <= eff_res_in;
      recip_ff    <= recip_in;
      eff_rank_ff <= eff_rank_in;
      eff_srv_ff  <= eff_srv_in;
   end

   always_comb begin
      case (idx)
         cpim_pkg::REG_RESOLUTION: prdata = DATA_W'(res_ff);
         cpim_pkg::REG_RANK:       prdata = DATA_W'(rank_ff);
         cpim_pkg::REG_SERVERS:    prdata = DATA_W'(srv_ff);
         default:                  prdata = '0;
      endcase
   end

   // ---------------- pipeline flow control ----------------
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [DEPTH-1:0] rdy;

   // A stage may load when it is empty or its contents move on.
   always_comb begin
      rdy[DEPTH-1] = !vld_ff[DEPTH-1] || !rsp_stall;
      for (int i = DEPTH - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < DEPTH; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[DEPTH-1];

   // The split number rides alongside the decoding lanes.
   logic [cpim_pkg::SPLIT_W-1:0] split_ff [LANE_D];

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         split_ff[0] <= req_data.split_index;
      end
      for (int k = 1; k < LANE_D; k++) begin
         if (rdy[k]) begin
            split_ff[k] <= split_ff[k-1];
         end
      end
   end

   // ---------------- lanes and merge ----------------
   logic [PACK_W-1:0] outer_pack, inner_pack;
   logic              outer_ovf, inner_ovf;

   cpim_lane #(
      .MAX_RANK   (MAX_RANK),
      .COORD_BITS (COORD_BITS)
   ) u_outer_lane (
      .clock    (clock),
      .en       (rdy[LANE_D-1:0]),
      .cell_idx (req_data.outer_cell),
      .eff_res  (eff_res_ff),
      .recip    (recip_ff),
      .eff_rank (eff_rank_ff),
      .coords   (outer_pack),
      .overflow (outer_ovf)
   );

   cpim_lane #(
      .MAX_RANK   (MAX_RANK),
      .COORD_BITS (COORD_BITS)
   ) u_inner_lane (
      .clock    (clock),
      .en       (rdy[LANE_D-1:0]),
      .cell_idx (req_data.inner_cell),
      .eff_res  (eff_res_ff),
      .recip    (recip_ff),
      .eff_rank (eff_rank_ff),
      .coords   (inner_pack),
      .overflow (inner_ovf)
   );

   cpim_merge #(
      .MAX_RANK   (MAX_RANK),
      .COORD_BITS (COORD_BITS)
   ) u_merge (
      .clock      (clock),
      .en         (rdy[DEPTH-1:LANE_D]),
      .outer_pack (outer_pack),
      .inner_pack (inner_pack),
      .outer_ovf  (outer_ovf),
      .inner_ovf  (inner_ovf),
      .split      (split_ff[LANE_D-1]),
      .eff_res    (eff_res_ff),
      .eff_srv    (eff_srv_ff),
      .rsp        (rsp_data)
   );

   // ---------------- assertions ----------------
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while the response side is moving");

   a_recip_matches_radix: assert property (@(posedge clock) disable iff (reset)
      ((32'(eff_res_ff) * 32'(recip_ff)) <= (32'd1 << RECIP_SHIFT))
      && ((32'(eff_res_ff) * (32'(recip_ff) + 32'd1)) > (32'd1 << RECIP_SHIFT)))
      else $error("reciprocal does not match the effective resolution");

   a_rank_clamped: assert property (@(posedge clock) disable iff (reset)
      (eff_rank_ff != '0) && (32'(eff_rank_ff) <= MAX_RANK))
      else $error("effective rank outside its range");

   a_rank_write: assert property (@(posedge clock) disable iff (reset)
      (wr && (idx == cpim_pkg::REG_RANK))
      |=> (rank_ff == $past(pwdata[cpim_pkg::RANK_REG_W-1:0])))
      else $error("rank register did not take the written value");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cell_pair_index_merge
// Drives requests with random sender gaps and receiver stalls, predicts each
// response from a behavioural model of the coordinate decode, pair check and
// digit interleave, and compares every field. Runs directed corner cases,
// then random phases over many grid settings, then a final stretch at full rate.
// ----------------------------------------------------------------------------
module testbench;

   localparam int              MAX_RANK    = 4;
   localparam int              COORD_BITS  = 4;
   localparam int              RADIX_TOP   = 1 << COORD_BITS;
   localparam longint unsigned CELL_CAP    = 64'h2_0000;
   localparam int              PIPE_DEPTH  = 4 * MAX_RANK;
   localparam int              MAX_REPORTS = 10;

   typedef enum int {SHAPE_ORDERED, SHAPE_IN_GRID, SHAPE_RAW} pair_shape_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   cpim_pkg::req_type           req_data;
   logic                        rsp_valid;
   logic                        rsp_stall;
   cpim_pkg::rsp_type           rsp_data;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [cpim_pkg::ADDR_W-1:0] paddr;
   logic [cpim_pkg::DATA_W-1:0] pwdata;
   logic [cpim_pkg::DATA_W-1:0] prdata;
   logic                        pready;

   // Shadow copies of the registers as last written.
   logic [cpim_pkg::RES_REG_W-1:0]  cfg_resolution;
   logic [cpim_pkg::RANK_REG_W-1:0] cfg_rank;
   logic [cpim_pkg::SRV_W-1:0]      cfg_servers;

   cpim_pkg::rsp_type pending_merges[$];
   int unsigned       error_count;
   bit                idle_on;

   cell_pair_index_merge #(
      .MAX_RANK  (MAX_RANK),
      .COORD_BITS(COORD_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic int unsigned eff_radix();
      int unsigned radix;
      radix = 32'(cfg_resolution);
      if (radix < 2) radix = 2;
      if (radix > RADIX_TOP) radix = RADIX_TOP;
      return radix;
   endfunction

   function automatic int unsigned eff_dims();
      int unsigned dims;
      dims = 32'(cfg_rank);
      if (dims < 1) dims = 1;
      if (dims > MAX_RANK) dims = MAX_RANK;
      return dims;
   endfunction

   // radix^d, capped well above any 16-bit cell index
   function automatic longint unsigned grid_span(int unsigned d);
      longint unsigned span;
      span = 1;
      for (int k = 0; k < d; k++) begin
         span = span * eff_radix();
         if (span > CELL_CAP) span = CELL_CAP;
      end
      return span;
   endfunction

   function automatic cpim_pkg::rsp_type merge_cells(cpim_pkg::req_type r);
      cpim_pkg::rsp_type res;
      int unsigned       radix;
      int unsigned       dims;
      longint unsigned   servers;
      longint unsigned   outer;
      longint unsigned   inner;
      longint unsigned   merged;
      longint unsigned   weight;
      longint unsigned   opack;
      longint unsigned   ipack;
      longint unsigned   place;
      longint unsigned   oc [0:MAX_RANK-1];
      longint unsigned   ic [0:MAX_RANK-1];
      bit                ordered;
      res     = '0;
      radix   = eff_radix();
      dims    = eff_dims();
      servers = 64'(cfg_servers);
      if (servers < 1) servers = 1;
      if (servers > cpim_pkg::SRV_MAX) servers = cpim_pkg::SRV_MAX;
      outer = 64'(r.outer_cell);
      inner = 64'(r.inner_cell);
      if (outer >= grid_span(dims) || inner >= grid_span(dims)) begin
         res.range_error = 1'b1;
         return res;
      end
      for (int k = 0; k < MAX_RANK; k++) begin
         oc[k] = 0;
         ic[k] = 0;
      end
      ordered = 1'b1;
      for (int i = int'(dims) - 1; i >= 0; i--) begin
         place = grid_span(i);
         oc[i] = outer / place;
         ic[i] = inner / place;
         outer = outer - oc[i] * place;
         inner = inner - ic[i] * place;
         if (oc[i] > ic[i]) ordered = 1'b0;
      end
      merged = 0;
      weight = 1;
      opack  = 0;
      ipack  = 0;
      for (int d = 0; d < dims; d++) begin
         merged = merged + oc[d] * weight;
         weight = weight * radix;
         merged = merged + ic[d] * weight;
         weight = weight * radix;
         opack  = opack | (oc[d] << (d * COORD_BITS));
         ipack  = ipack | (ic[d] << (d * COORD_BITS));
      end
      res.pair_valid   = ordered;
      res.outer_coords = cpim_pkg::COORDS_W'(opack);
      res.inner_coords = cpim_pkg::COORDS_W'(ipack);
      if (ordered) begin
         merged             = merged & 64'hFFFF_FFFF;
         res.merged_index   = cpim_pkg::MERGED_W'(merged);
         res.extended_index = cpim_pkg::EXT_W'(longint'(r.split_index) + servers * merged);
      end
      return res;
   endfunction

   function automatic cpim_pkg::req_type draw_request(pair_shape_type shape);
      cpim_pkg::req_type r;
      int unsigned       radix;
      int unsigned       hi;
      int unsigned       lo;
      longint unsigned   place;
      longint unsigned   outer;
      longint unsigned   inner;
      radix         = eff_radix();
      r.split_index = cpim_pkg::SPLIT_W'($urandom);
      case (shape)
         SHAPE_ORDERED: begin
            // each outer digit at most the matching inner digit
            outer = 0;
            inner = 0;
            place = 1;
            for (int d = 0; d < eff_dims(); d++) begin
               hi    = $urandom_range(radix - 1, 0);
               lo    = $urandom_range(hi, 0);
               outer = outer + lo * place;
               inner = inner + hi * place;
               place = place * radix;
            end
            r.outer_cell = cpim_pkg::CELL_W'(outer);
            r.inner_cell = cpim_pkg::CELL_W'(inner);
         end
         SHAPE_IN_GRID: begin
            r.outer_cell = cpim_pkg::CELL_W'(
               $urandom_range(int'(grid_span(eff_dims()) - 1), 0));
            r.inner_cell = cpim_pkg::CELL_W'(
               $urandom_range(int'(grid_span(eff_dims()) - 1), 0));
         end
         default: begin
            r.outer_cell = cpim_pkg::CELL_W'($urandom);
            r.inner_cell = cpim_pkg::CELL_W'($urandom);
         end
      endcase
      return r;
   endfunction

   function automatic pair_shape_type pick_shape();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 60) return SHAPE_ORDERED;
      if (roll < 85) return SHAPE_IN_GRID;
      return SHAPE_RAW;
   endfunction

   task automatic log_failure(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endtask

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want)
         log_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
   endtask

   always @(posedge clock) begin : response_check
      cpim_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_merges.size() == 0) begin
               log_failure($sformatf("response %h with no request outstanding", rsp_data));
            end else begin
               want = pending_merges.pop_front();
               compare_field("pair_valid", 64'(want.pair_valid),
                             64'(rsp_data.pair_valid));
               compare_field("range_error", 64'(want.range_error),
                             64'(rsp_data.range_error));
               compare_field("merged_index", 64'(want.merged_index),
                             64'(rsp_data.merged_index));
               compare_field("extended_index", 64'(want.extended_index),
                             64'(rsp_data.extended_index));
               compare_field("outer_coords", 64'(want.outer_coords),
                             64'(rsp_data.outer_coords));
               compare_field("inner_coords", 64'(want.inner_coords),
                             64'(rsp_data.inner_coords));
            end
         end
         if (req_valid && !req_stall) pending_merges = {pending_merges, merge_cells(req_data)};
      end
   end

   initial begin : receiver_stall
      int unsigned burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(5, 0) == 0) begin
            burst = $urandom_range(5, 1);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic drive_request(cpim_pkg::req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_pair(int unsigned outer, int unsigned inner, int unsigned split);
      cpim_pkg::req_type item;
      item.outer_cell  = cpim_pkg::CELL_W'(outer);
      item.inner_cell  = cpim_pkg::CELL_W'(inner);
      item.split_index = cpim_pkg::SPLIT_W'(split);
      drive_request(item);
   endtask

   task automatic sender_pause(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic wait_for_responses();
      sender_pause(1);
      while (pending_merges.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [cpim_pkg::REG_IDX_W-1:0] idx,
                                 logic [cpim_pkg::DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         cpim_pkg::REG_RESOLUTION: cfg_resolution = value[cpim_pkg::RES_REG_W-1:0];
         cpim_pkg::REG_RANK:       cfg_rank       = value[cpim_pkg::RANK_REG_W-1:0];
         cpim_pkg::REG_SERVERS:    cfg_servers    = value[cpim_pkg::SRV_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // The registers are only rewritten once every request has drained.
   task automatic set_grid(int unsigned res, int unsigned dims, int unsigned servers);
      wait_for_responses();
      write_register(cpim_pkg::REG_RESOLUTION, res);
      write_register(cpim_pkg::REG_RANK, dims);
      write_register(cpim_pkg::REG_SERVERS, servers);
   endtask

   task automatic test_reset_values();
      send_pair(0, 0, 0);
      send_pair(255, 255, 255);
      send_pair(256, 0, 0);
      send_pair(0, 256, 1);
      send_pair(16'hFFFF, 16'hFFFF, 255);
      send_pair(16'h21, 16'h12, 9);
      send_pair(16'h12, 16'h21, 16'h80);
      wait_for_responses();
   endtask

   task automatic test_smallest_grid();
      set_grid(2, 1, 1);
      send_pair(0, 1, 0);
      send_pair(1, 0, 3);
      send_pair(1, 2, 0);
      send_pair(1, 1, 255);
      wait_for_responses();
   endtask

   task automatic test_largest_grid();
      set_grid(16, 4, 256);
      send_pair(0, 16'hFFFF, 255);
      send_pair(16'hFFFF, 16'hFFFF, 255);
      send_pair(16'h1234, 16'h2345, 77);
      send_pair(16'h2345, 16'h1234, 77);
      wait_for_responses();
   endtask

   // Register values outside the legal ranges are clamped by the block.
   task automatic test_register_clamping();
      set_grid(0, 0, 0);
      send_pair(1, 1, 7);
      send_pair(0, 2, 0);
      set_grid(31, 7, 511);
      send_pair(16'hFFFF, 16'hFFFF, 0);
      send_pair(16'h0F0F, 16'hF0F0, 200);
      set_grid(17, 5, 300);
      send_pair(1, 2, 16'h10);
      set_grid(1, 3, 257);
      send_pair(3, 7, 255);
      wait_for_responses();
   endtask

   task automatic test_odd_radix();
      set_grid(3, 2, 3);
      send_pair(8, 8, 1);
      send_pair(8, 9, 1);
      send_pair(4, 5, 100);
      wait_for_responses();
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         idle_on = (phase % 3 != 2);
         if (phase == 0)
            set_grid(2, 1, 1);
         else if (phase == 1)
            set_grid(16, 4, 256);
         else
            set_grid(($urandom_range(9, 0) == 0) ? $urandom_range(31, 0)
                                                 : $urandom_range(16, 2),
                     ($urandom_range(7, 0) == 0) ? $urandom_range(7, 0)
                                                 : $urandom_range(4, 1),
                     ($urandom_range(7, 0) == 0) ? $urandom_range(511, 0)
                                                 : $urandom_range(256, 1));
         for (int n = 0; n < 110; n++) begin
            // halfway through one phase the sender holds off until all have drained
            if (phase == 4 && n == 55) wait_for_responses();
            if (idle_on && $urandom_range(4, 0) == 0) sender_pause($urandom_range(5, 1));
            drive_request(draw_request(pick_shape()));
         end
         wait_for_responses();
      end
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      set_grid(10, 3, 7);
      repeat (150) drive_request(draw_request(pick_shape()));
      wait_for_responses();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      idle_on        = 1'b1;
      error_count    = 0;
      cfg_resolution = cpim_pkg::RES_RESET;
      cfg_rank       = cpim_pkg::RANK_RESET;
      cfg_servers    = cpim_pkg::SRV_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_smallest_grid();
      test_largest_grid();
      test_register_clamping();
      test_odd_radix();
      test_random_phases();
      test_full_rate();

      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (pending_merges.size() != 0)
         log_failure($sformatf("%0d responses never arrived", pending_merges.size()));
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/cpim_pkg.sv
hdl/cpim_lane.sv
hdl/cpim_merge.sv
hdl/cell_pair_index_merge.sv
tb/testbench.sv
